// ----- design/dvbf_pkg.sv -----
// Shared types and constants of the distance-vector shortest path block.
package dvbf_pkg;

	localparam int ID_W      = 3;
	localparam int COST_W    = 7;
	localparam int CFG_IDX_W = 1;
	localparam int MAX_ID    = (1 << ID_W) - 1;

	localparam logic [COST_W-1:0] NO_LINK = 7'd99;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_EVAL  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SELF_ID    = 1'b1;

	localparam logic [ID_W-1:0] NODE_COUNT_RST = 3'd5;
	localparam logic [ID_W-1:0] SELF_ID_RST    = 3'd1;

	typedef struct packed {
		logic            mat_wr;
		logic            init_dist;
		logic            load_s;
		logic            issue;
		logic            out_load;
		logic            out_last;
		logic [ID_W-1:0] s;
		logic [ID_W-1:0] d;
		logic [ID_W-1:0] j;
	} dvbf_cmd_t;

	typedef struct packed {
		logic [ID_W-1:0] n_eff;
		logic            out_free;
	} dvbf_stat_t;

endpackage

// ----- design/distance_vector_bellman_ford.sv -----
// Top level of the distance-vector shortest path block (Bellman-Ford on a cost matrix).
//
//  channel  direction  handshake             word
//  in       sink       in_valid / in_stall   cmd, from_node, to_node, link_cost
//  out      source     out_valid / out_stall dest_node, path_cost, last
//  cfg      sink       cfg_wr_en             cfg_index, cfg_data
//
// During an evaluate word the cost matrix RAM delivers one entry per cycle, and
// each source row ends with a gap state that lets its last update settle before
// the source distance is reloaded.
// Reset clears the matrix through per-entry valid bits at once; no clearing pass.
// Output stalls hold the result word and pause the result sequence; the input
// is stalled from the accepted evaluate word until its last result is loaded.
module distance_vector_bellman_ford #(
	parameter int MAX_NODES = 7
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [dvbf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dvbf_pkg::ID_W-1:0]       cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            cmd,
	input  logic [dvbf_pkg::ID_W-1:0]       from_node,
	input  logic [dvbf_pkg::ID_W-1:0]       to_node,
	input  logic [dvbf_pkg::COST_W-1:0]     link_cost,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [dvbf_pkg::ID_W-1:0]       dest_node,
	output logic [dvbf_pkg::COST_W-1:0]     path_cost,
	output logic                            last
);
	import dvbf_pkg::*;

	dvbf_cmd_t  ctl;
	dvbf_stat_t sts;

	// sequencer: row/column walk, rounds, result count
	dvbf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.cmd     (cmd),
		.in_stall(in_stall),
		.sts     (sts),
		.ctl     (ctl)
	);

	// storage and arithmetic: matrix RAM, distances, relax compare, output word
	dvbf_datapath #(
		.MAX_NODES(MAX_NODES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.from_node(from_node),
		.to_node  (to_node),
		.link_cost(link_cost),
		.ctl      (ctl),
		.sts      (sts),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.dest_node(dest_node),
		.path_cost(path_cost),
		.last     (last)
	);

endmodule

// ----- design/dvbf_ram.sv -----
// Generic single-port-write RAM with one registered read port.
module dvbf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ----- design/dvbf_datapath.sv -----
// Datapath: config registers, cost matrix, distance registers, relax unit, output word.
module dvbf_datapath #(
	parameter int MAX_NODES = 7
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [dvbf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dvbf_pkg::ID_W-1:0]       cfg_data,
	input  logic [dvbf_pkg::ID_W-1:0]       from_node,
	input  logic [dvbf_pkg::ID_W-1:0]       to_node,
	input  logic [dvbf_pkg::COST_W-1:0]     link_cost,
	input  dvbf_pkg::dvbf_cmd_t             ctl,
	output dvbf_pkg::dvbf_stat_t            sts,
	input  logic                            out_stall,
	output logic                            out_valid,
	output logic [dvbf_pkg::ID_W-1:0]       dest_node,
	output logic [dvbf_pkg::COST_W-1:0]     path_cost,
	output logic                            last
);
	import dvbf_pkg::*;

	// ids above the port range never reach the matrix
	localparam int LIM       = (MAX_NODES < MAX_ID) ? MAX_NODES : MAX_ID;
	localparam int DIM       = LIM + 1;
	localparam int IDX_W     = $clog2(DIM);
	localparam int DV_DEPTH  = 2 ** IDX_W;
	localparam int MAT_AW    = 2 * IDX_W;
	localparam int MAT_DEPTH = 2 ** MAT_AW;
	localparam logic [ID_W-1:0] LIM_ID = ID_W'(LIM);

	logic [ID_W-1:0]   node_count_q;
	logic [ID_W-1:0]   self_id_q;
	logic [ID_W-1:0]   n_eff;
	logic              self_in;
	logic              wb_ok;

	logic              ram_we;
	logic [MAT_AW-1:0] ram_waddr;
	logic [COST_W-1:0] ram_wdata;
	logic [MAT_AW-1:0] ram_raddr;
	logic [COST_W-1:0] ram_rdata;
	logic              user_wr;
	logic              wb_wr;
	logic [COST_W-1:0] clamp_cost;

	logic              vld_q [MAT_DEPTH];
	logic              vld_s1;
	logic              issue_s1;
	logic [IDX_W-1:0]  s_s1;
	logic [IDX_W-1:0]  d_s1;

	logic [COST_W-1:0] dist_q [DV_DEPTH];
	logic [COST_W-1:0] dist_s_q;
	logic [IDX_W-1:0]  dv_idx;
	logic [COST_W-1:0] dist_rd;
	logic [COST_W-1:0] w_raw;
	logic [COST_W-1:0] w_eff;
	logic [COST_W:0]   sum;
	logic              relax_wr;

	logic              out_valid_q;
	logic [ID_W-1:0]   dest_q;
	logic [COST_W-1:0] cost_q;
	logic              last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RST;
			self_id_q    <= SELF_ID_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_NODE_COUNT: node_count_q <= cfg_data;
				REG_SELF_ID:    self_id_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign n_eff   = (node_count_q > LIM_ID) ? LIM_ID : node_count_q;
	assign self_in = (self_id_q != '0) && (self_id_q <= n_eff);
	assign wb_ok   = (self_id_q <= LIM_ID);

	assign clamp_cost = (link_cost > NO_LINK) ? NO_LINK : link_cost;
	assign user_wr    = ctl.mat_wr && (from_node <= LIM_ID) && (to_node <= LIM_ID);
	assign wb_wr      = ctl.out_load && wb_ok;
	assign ram_we     = user_wr || wb_wr;
	assign ram_waddr  = user_wr ? {from_node[IDX_W-1:0], to_node[IDX_W-1:0]}
	                            : {self_id_q[IDX_W-1:0], ctl.j[IDX_W-1:0]};
	assign ram_wdata  = user_wr ? clamp_cost : dist_rd;
	assign ram_raddr  = {ctl.s[IDX_W-1:0], ctl.d[IDX_W-1:0]};

	dvbf_ram #(
		.WIDTH(COST_W),
		.DEPTH(MAT_DEPTH)
	) u_mat (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ram_waddr),
		.wr_data(ram_wdata),
		.rd_addr(ram_raddr),
		.rd_data(ram_rdata)
	);

	// entries never written read as no link
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAT_DEPTH; k++) begin
				vld_q[k] <= 1'b0;
			end
		end else if (ram_we) begin
			vld_q[ram_waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1 <= 1'b0;
		end else begin
			issue_s1 <= ctl.issue;
		end
	end

	always_ff @(posedge clk) begin
		vld_s1 <= vld_q[ram_raddr];
		s_s1   <= ctl.s[IDX_W-1:0];
		d_s1   <= ctl.d[IDX_W-1:0];
	end

	// one distance read port, shared by relax, row load and output
	always_comb begin
		if (issue_s1) begin
			dv_idx = d_s1;
		end else if (ctl.load_s) begin
			dv_idx = ctl.s[IDX_W-1:0];
		end else begin
			dv_idx = ctl.j[IDX_W-1:0];
		end
	end
	assign dist_rd = dist_q[dv_idx];

	// normalize on the fly: diagonal is 0, an off-diagonal 0 is no link
	assign w_raw = vld_s1 ? ram_rdata : NO_LINK;
	always_comb begin
		if (s_s1 == d_s1) begin
			w_eff = '0;
		end else if (w_raw == '0) begin
			w_eff = NO_LINK;
		end else begin
			w_eff = w_raw;
		end
	end
	assign sum      = {1'b0, dist_s_q} + {1'b0, w_eff};
	assign relax_wr = issue_s1 && (w_eff != NO_LINK) && (sum < {1'b0, dist_rd});

	always_ff @(posedge clk) begin
		if (ctl.init_dist) begin
			for (int k = 0; k < DV_DEPTH; k++) begin
				dist_q[k] <= (self_in && (self_id_q == ID_W'(k))) ? '0 : NO_LINK;
			end
		end else if (relax_wr) begin
			dist_q[d_s1] <= sum[COST_W-1:0];
		end
		if (ctl.load_s) begin
			dist_s_q <= dist_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			dest_q <= ctl.j;
			cost_q <= dist_rd;
			last_q <= ctl.out_last;
		end
	end

	assign sts.n_eff    = n_eff;
	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign dest_node = dest_q;
	assign path_cost = cost_q;
	assign last      = last_q;

endmodule

// ----- design/dvbf_ctrl.sv -----
// Controller: sequences writes, relaxation rounds and the result words.
module dvbf_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  cmd,
	output logic                  in_stall,
	input  dvbf_pkg::dvbf_stat_t  sts,
	output dvbf_pkg::dvbf_cmd_t   ctl
);
	import dvbf_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_INIT  = 6'b000010,
		ST_LOAD  = 6'b000100,
		ST_ISSUE = 6'b001000,
		ST_GAP   = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	localparam logic [ID_W-1:0] ONE = 3'd1;

	state_t          state_q;
	logic [ID_W-1:0] round_q;
	logic [ID_W-1:0] s_q;
	logic [ID_W-1:0] d_q;
	logic [ID_W-1:0] j_q;
	logic            in_acc;
	logic            issuing;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign issuing  = (state_q == ST_LOAD) || (state_q == ST_ISSUE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			round_q <= ONE;
			s_q     <= ONE;
			d_q     <= ONE;
			j_q     <= ONE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc && (cmd == CMD_EVAL) && (sts.n_eff != '0)) begin
						state_q <= ST_INIT;
					end
				end
				ST_INIT: begin
					round_q <= ONE;
					s_q     <= ONE;
					d_q     <= ONE;
					j_q     <= ONE;
					state_q <= (sts.n_eff == ONE) ? ST_OUT : ST_LOAD;
				end
				ST_LOAD, ST_ISSUE: begin
					if (d_q == sts.n_eff) begin
						d_q     <= ONE;
						state_q <= ST_GAP;
					end else begin
						d_q     <= d_q + ONE;
						state_q <= ST_ISSUE;
					end
				end
				ST_GAP: begin
					if (s_q != sts.n_eff) begin
						s_q     <= s_q + ONE;
						state_q <= ST_LOAD;
					end else if (round_q == sts.n_eff - ONE) begin
						state_q <= ST_OUT;
					end else begin
						round_q <= round_q + ONE;
						s_q     <= ONE;
						state_q <= ST_LOAD;
					end
				end
				ST_OUT: begin
					if (sts.out_free) begin
						if (j_q == sts.n_eff) begin
							state_q <= ST_IDLE;
						end else begin
							j_q <= j_q + ONE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		ctl           = '0;
		ctl.mat_wr    = in_acc && (cmd == CMD_WRITE);
		ctl.init_dist = (state_q == ST_INIT);
		ctl.load_s    = (state_q == ST_LOAD);
		ctl.issue     = issuing;
		ctl.out_load  = (state_q == ST_OUT) && sts.out_free;
		ctl.out_last  = (j_q == sts.n_eff);
		ctl.s         = s_q;
		ctl.d         = d_q;
		ctl.j         = j_q;
	end

endmodule

// ----- design/dvbf_checker.sv -----
// Port-level checker for the distance-vector block, with its bind.
module dvbf_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [dvbf_pkg::ID_W-1:0]   dest_node,
	input logic [dvbf_pkg::COST_W-1:0] path_cost,
	input logic                        last
);
	import dvbf_pkg::*;

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(dest_node) && $stable(path_cost)
			&& $stable(last))
		else $error("result word changed under stall");

	// node zero is never a destination
	a_dest_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> dest_node != '0)
		else $error("result for node zero");

	// distances stay within the no-link bound
	a_cost_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> path_cost <= NO_LINK)
		else $error("path cost above no-link value");

	// input stays stalled while an evaluation still owes results
	a_busy_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> in_stall)
		else $error("input taken in the middle of a result run");

endmodule

bind distance_vector_bellman_ford dvbf_checker u_chk (.*);
